// File: design/per_device_alarm_table_macros.svh
// assertion macros used by the alarm table datapath
`ifndef PER_DEVICE_ALARM_TABLE_MACROS_SVH
`define PER_DEVICE_ALARM_TABLE_MACROS_SVH

// condition holds in the same cycle
`define PDAT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// condition holds in the next cycle
`define PDAT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/pdat_pkg.sv
// types, codes and defaults shared by the alarm table modules
package pdat_pkg;

    localparam int MAX_DEVICES_DEF       = 16;
    localparam int ALARMS_PER_DEVICE_DEF = 8;
    localparam int IN_TDATA_W            = 120;
    localparam int OUT_TDATA_W           = 136;

    localparam logic [2:0] REQ_NOTIFY    = 3'd0;
    localparam logic [2:0] REQ_REPORT    = 3'd1;
    localparam logic [2:0] REQ_REMOVE    = 3'd2;
    localparam logic [2:0] REQ_CLR_DEV   = 3'd3;
    localparam logic [2:0] REQ_CLR_ALL   = 3'd4;
    localparam logic [2:0] REQ_QUERY     = 3'd5;
    localparam logic [2:0] REQ_SPARE_A   = 3'd6;
    localparam logic [2:0] REQ_SPARE_B   = 3'd7;

    localparam logic [1:0] STS_OK        = 2'd0;
    localparam logic [1:0] STS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STS_FULL      = 2'd2;
    localparam logic [1:0] STS_DISABLED  = 2'd3;

    localparam logic [2:0] REG_ENABLE    = 3'd0;

    typedef struct packed {
        logic [4:0]  pad;
        logic [31:0] now_time;
        logic [31:0] report_time;
        logic [15:0] cluster_in;
        logic [7:0]  code_in;
        logic [7:0]  endpoint_num;
        logic [15:0] device_addr;
        logic [2:0]  req_type;
    } req_t;

    typedef struct packed {
        logic        pad;
        logic [31:0] cleared_total;
        logic [31:0] received_total;
        logic [7:0]  device_endpoint;
        logic [31:0] latest_stamp;
        logic [15:0] latest_cluster;
        logic [7:0]  latest_code;
        logic        latest_found;
        logic [3:0]  alarm_cnt;
        logic [1:0]  status;
    } res_t;

    typedef struct packed {
        logic [7:0]  code;
        logic [15:0] cluster;
        logic [31:0] stamp;
    } alarm_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_DISABLE, OP_CA_RD, OP_CA_WR, OP_CA_END,
        OP_DEV_RD, OP_DEV_CMP, OP_CREATE, OP_DROP, OP_NOTFOUND, OP_CLR_DEV,
        OP_AL_RD, OP_AL_CMP, OP_PUT, OP_SH_RD, OP_SH_WR, OP_RM_END,
        OP_Q_END, OP_EMIT
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic [2:0] req;
        logic       dfound;
        logic       dev_match;
        logic       idx_end;
        logic       used_full;
        logic       cnt_zero;
        logic       j_end;
        logic       al_match;
        logic       afound;
        logic       sh_end;
        logic       out_free;
    } dp_stat_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DIS, ST_CA_RD, ST_CA_WR, ST_DEV_RD, ST_DEV_CMP, ST_DISPATCH,
        ST_AL_RD, ST_AL_CMP, ST_AL_END, ST_SH_CHK, ST_SH_WR, ST_FINISH
    } state_t;

endpackage

// File: design/pdat_ctrl.sv
// request sequencer of the alarm table
module pdat_ctrl import pdat_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  logic     enabled,
    input  logic [2:0] in_req,
    input  dp_stat_t stat,
    output cmd_t     cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (!enabled) state_next = ST_DIS;
                    else if (in_req == REQ_CLR_ALL) state_next = ST_CA_RD;
                    else state_next = ST_DEV_RD;
                end
            end
            ST_DIS:     state_next = ST_FINISH;
            ST_CA_RD:   state_next = stat.idx_end ? ST_DEV_RD : ST_CA_WR;
            ST_CA_WR:   state_next = ST_CA_RD;
            ST_DEV_RD:  state_next = stat.idx_end ? ST_DISPATCH : ST_DEV_CMP;
            ST_DEV_CMP: state_next = stat.dev_match ? ST_DISPATCH : ST_DEV_RD;
            ST_DISPATCH: begin
                case (stat.req)
                    REQ_NOTIFY, REQ_REPORT: begin
                        if (stat.dfound || !stat.used_full) state_next = ST_AL_RD;
                        else state_next = ST_FINISH;
                    end
                    REQ_REMOVE: state_next = stat.dfound ? ST_AL_RD : ST_FINISH;
                    REQ_QUERY: begin
                        if (stat.dfound && !stat.cnt_zero) state_next = ST_AL_RD;
                        else state_next = ST_FINISH;
                    end
                    default: state_next = ST_FINISH;
                endcase
            end
            ST_AL_RD:  state_next = stat.j_end ? ST_AL_END : ST_AL_CMP;
            ST_AL_CMP: state_next = stat.al_match ? ST_AL_END : ST_AL_RD;
            ST_AL_END: begin
                if (stat.req == REQ_REMOVE && stat.afound) state_next = ST_SH_CHK;
                else state_next = ST_FINISH;
            end
            ST_SH_CHK: state_next = stat.sh_end ? ST_FINISH : ST_SH_WR;
            ST_SH_WR:  state_next = ST_SH_CHK;
            ST_FINISH: state_next = stat.out_free ? ST_IDLE : ST_FINISH;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd.op   = OP_NONE;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) cmd.op = OP_LOAD;
            end
            ST_DIS:     cmd.op = OP_DISABLE;
            ST_CA_RD:   cmd.op = stat.idx_end ? OP_CA_END : OP_CA_RD;
            ST_CA_WR:   cmd.op = OP_CA_WR;
            ST_DEV_RD:  cmd.op = stat.idx_end ? OP_NONE : OP_DEV_RD;
            ST_DEV_CMP: cmd.op = OP_DEV_CMP;
            ST_DISPATCH: begin
                case (stat.req)
                    REQ_NOTIFY, REQ_REPORT: begin
                        if (!stat.dfound) cmd.op = stat.used_full ? OP_DROP : OP_CREATE;
                    end
                    REQ_REMOVE:  if (!stat.dfound) cmd.op = OP_NOTFOUND;
                    REQ_CLR_DEV: if (stat.dfound) cmd.op = OP_CLR_DEV;
                    REQ_QUERY: begin
                        if (!stat.dfound || stat.cnt_zero) cmd.op = OP_NOTFOUND;
                    end
                    default: cmd.op = OP_NONE;
                endcase
            end
            ST_AL_RD:  cmd.op = stat.j_end ? OP_NONE : OP_AL_RD;
            ST_AL_CMP: cmd.op = OP_AL_CMP;
            ST_AL_END: begin
                case (stat.req)
                    REQ_NOTIFY, REQ_REPORT: cmd.op = OP_PUT;
                    REQ_REMOVE: cmd.op = stat.afound ? OP_NONE : OP_NOTFOUND;
                    REQ_QUERY:  cmd.op = OP_Q_END;
                    default:    cmd.op = OP_NONE;
                endcase
            end
            ST_SH_CHK: cmd.op = stat.sh_end ? OP_RM_END : OP_SH_RD;
            ST_SH_WR:  cmd.op = OP_SH_WR;
            ST_FINISH: if (stat.out_free) cmd.op = OP_EMIT;
            default:   cmd.op = OP_NONE;
        endcase
    end

endmodule

// File: design/pdat_dp.sv
// alarm table storage, search registers, counters and result register
`include "per_device_alarm_table_macros.svh"

module pdat_dp import pdat_pkg::*; #(
    parameter int MAX_DEVICES       = MAX_DEVICES_DEF,
    parameter int ALARMS_PER_DEVICE = ALARMS_PER_DEVICE_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  req_t     req_in,
    input  cmd_t     cmd,
    output dp_stat_t stat,
    input  logic     m_tready,
    output logic     m_tvalid,
    output res_t     res
);

    localparam int DW    = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
    localparam int DIW   = $clog2(MAX_DEVICES + 1);
    localparam int CW    = $clog2(ALARMS_PER_DEVICE + 1);
    localparam int SLOTS = MAX_DEVICES * ALARMS_PER_DEVICE;
    localparam int AIW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [2:0]     req_reg;
    logic [15:0]    addr_reg;
    logic [7:0]     ep_in_reg;
    logic [7:0]     code_reg;
    logic [15:0]    clus_reg;
    logic [31:0]    t_reg;
    logic [DIW-1:0] idx_reg;
    logic [DIW-1:0] used_reg;
    logic [DW-1:0]  dev_reg;
    logic           dfound_reg;
    logic [CW-1:0]  cnt_reg;
    logic [7:0]     ep_reg;
    logic [CW-1:0]  j_reg;
    logic           afound_reg;
    logic [CW-1:0]  slot_reg;
    logic [31:0]    min_time_reg;
    logic [CW-1:0]  min_slot_reg;
    alarm_t         max_reg;
    logic [1:0]     status_reg;
    logic           lfound_reg;
    logic [31:0]    recv_reg;
    logic [31:0]    clr_reg;
    logic           out_valid_reg;
    res_t           out_reg;

    logic [15:0]   dev_addr_mem [MAX_DEVICES];
    logic [7:0]    dev_ep_mem   [MAX_DEVICES];
    logic [CW-1:0] dev_cnt_mem  [MAX_DEVICES];
    alarm_t        al_mem       [SLOTS];
    logic [15:0]   addr_rd_reg;
    logic [7:0]    ep_rd_reg;
    logic [CW-1:0] cnt_rd_reg;
    alarm_t        al_rd_reg;

    logic           al_match;
    logic           cnt_full;
    logic [DW-1:0]  idx_a;
    logic [DW-1:0]  used_a;
    logic [CW-1:0]  rd_off;
    logic [CW-1:0]  wr_off;
    logic [AIW-1:0] base;
    logic [AIW-1:0] al_rd_addr;
    logic [AIW-1:0] al_wr_addr;
    logic           al_we;
    alarm_t         al_wd;
    logic           cnt_we;
    logic [DW-1:0]  cnt_wa;
    logic [CW-1:0]  cnt_wd;
    logic [CW:0]    j_plus;

    assign idx_a    = idx_reg[DW-1:0];
    assign used_a   = used_reg[DW-1:0];
    assign al_match = (req_reg != REQ_QUERY) && (al_rd_reg.code == code_reg)
                      && (al_rd_reg.cluster == clus_reg);
    assign cnt_full = (cnt_reg == CW'(ALARMS_PER_DEVICE));
    assign j_plus   = {1'b0, j_reg} + (CW+1)'(1);
    assign base     = AIW'(dev_reg) * AIW'(ALARMS_PER_DEVICE);
    assign rd_off   = (cmd.op == OP_SH_RD) ? j_plus[CW-1:0] : j_reg;
    assign al_rd_addr = base + AIW'(rd_off);
    assign al_wr_addr = base + AIW'(wr_off);

    // alarm write port: shift step or new/updated entry
    always_comb begin
        al_we  = 1'b0;
        al_wd  = '{code: code_reg, cluster: clus_reg, stamp: t_reg};
        wr_off = j_reg;
        case (cmd.op)
            OP_SH_WR: begin
                al_we = 1'b1;
                al_wd = al_rd_reg;
            end
            OP_PUT: begin
                al_we = 1'b1;
                if (afound_reg) wr_off = slot_reg;
                else if (cnt_full) wr_off = min_slot_reg;
                else wr_off = cnt_reg;
            end
            default: al_we = 1'b0;
        endcase
    end

    // count store write port
    always_comb begin
        cnt_we = 1'b0;
        cnt_wa = dev_reg;
        cnt_wd = '0;
        case (cmd.op)
            OP_CREATE: begin
                cnt_we = 1'b1;
                cnt_wa = used_a;
            end
            OP_PUT: begin
                cnt_we = !afound_reg && !cnt_full;
                cnt_wd = cnt_reg + CW'(1);
            end
            OP_RM_END: begin
                cnt_we = 1'b1;
                cnt_wd = cnt_reg - CW'(1);
            end
            OP_CLR_DEV: cnt_we = 1'b1;
            OP_CA_WR: begin
                cnt_we = 1'b1;
                cnt_wa = idx_a;
            end
            default: cnt_we = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        addr_rd_reg <= dev_addr_mem[idx_a];
        ep_rd_reg   <= dev_ep_mem[idx_a];
        cnt_rd_reg  <= dev_cnt_mem[idx_a];
        al_rd_reg   <= al_mem[al_rd_addr];
        if (cmd.op == OP_CREATE) begin
            dev_addr_mem[used_a] <= addr_reg;
            dev_ep_mem[used_a]   <= ep_in_reg;
        end
        if (cnt_we) dev_cnt_mem[cnt_wa] <= cnt_wd;
        if (al_we) al_mem[al_wr_addr] <= al_wd;
    end

    // control state and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg      <= '0;
            recv_reg      <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.op == OP_EMIT) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            case (cmd.op)
                OP_CREATE: used_reg <= used_reg + DIW'(1);
                OP_DROP: if (req_reg == REQ_NOTIFY) recv_reg <= recv_reg + 32'd1;
                OP_PUT:  if (req_reg == REQ_NOTIFY) recv_reg <= recv_reg + 32'd1;
                OP_RM_END:  clr_reg <= clr_reg + 32'd1;
                OP_CLR_DEV: clr_reg <= clr_reg + 32'(cnt_reg);
                OP_CA_WR:   clr_reg <= clr_reg + 32'(cnt_rd_reg);
                default: ;
            endcase
        end
    end

    // per-request working registers
    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LOAD: begin
                req_reg    <= req_in.req_type;
                addr_reg   <= req_in.device_addr;
                ep_in_reg  <= req_in.endpoint_num;
                code_reg   <= req_in.code_in;
                clus_reg   <= req_in.cluster_in;
                if (req_in.req_type == REQ_NOTIFY || req_in.report_time == 32'd0) begin
                    t_reg <= req_in.now_time;
                end else begin
                    t_reg <= req_in.report_time;
                end
                idx_reg    <= '0;
                dfound_reg <= 1'b0;
                cnt_reg    <= '0;
                ep_reg     <= '0;
                j_reg      <= '0;
                afound_reg <= 1'b0;
                status_reg <= STS_OK;
                lfound_reg <= 1'b0;
            end
            OP_DISABLE:  status_reg <= STS_DISABLED;
            OP_DROP:     status_reg <= STS_FULL;
            OP_NOTFOUND: status_reg <= STS_NOT_FOUND;
            OP_CA_WR:    idx_reg <= idx_reg + DIW'(1);
            OP_CA_END:   idx_reg <= '0;
            OP_DEV_CMP: begin
                if (addr_rd_reg == addr_reg) begin
                    dfound_reg <= 1'b1;
                    dev_reg    <= idx_a;
                    cnt_reg    <= cnt_rd_reg;
                    ep_reg     <= ep_rd_reg;
                end else begin
                    idx_reg <= idx_reg + DIW'(1);
                end
            end
            OP_CREATE: begin
                dev_reg    <= used_a;
                dfound_reg <= 1'b1;
                cnt_reg    <= '0;
                ep_reg     <= ep_in_reg;
            end
            OP_AL_CMP: begin
                // oldest: strict less keeps the lowest slot; newest: ties move up
                if (j_reg == '0 || al_rd_reg.stamp < min_time_reg) begin
                    min_time_reg <= al_rd_reg.stamp;
                    min_slot_reg <= j_reg;
                end
                if (j_reg == '0 || al_rd_reg.stamp >= max_reg.stamp) max_reg <= al_rd_reg;
                if (al_match) begin
                    afound_reg <= 1'b1;
                    slot_reg   <= j_reg;
                end else begin
                    j_reg <= j_reg + CW'(1);
                end
            end
            OP_PUT:     if (!afound_reg && !cnt_full) cnt_reg <= cnt_reg + CW'(1);
            OP_SH_WR:   j_reg <= j_reg + CW'(1);
            OP_RM_END:  cnt_reg <= cnt_reg - CW'(1);
            OP_CLR_DEV: cnt_reg <= '0;
            OP_Q_END:   lfound_reg <= 1'b1;
            OP_EMIT: begin
                out_reg.pad             <= 1'b0;
                out_reg.status          <= status_reg;
                out_reg.alarm_cnt       <= dfound_reg ? 4'(cnt_reg) : 4'd0;
                out_reg.latest_found    <= lfound_reg;
                out_reg.latest_code     <= lfound_reg ? max_reg.code : 8'd0;
                out_reg.latest_cluster  <= lfound_reg ? max_reg.cluster : 16'd0;
                out_reg.latest_stamp    <= lfound_reg ? max_reg.stamp : 32'd0;
                out_reg.device_endpoint <= dfound_reg ? ep_reg : 8'd0;
                out_reg.received_total  <= recv_reg;
                out_reg.cleared_total   <= clr_reg;
            end
            default: ;
        endcase
    end

    assign stat.req       = req_reg;
    assign stat.dfound    = dfound_reg;
    assign stat.dev_match = (addr_rd_reg == addr_reg);
    assign stat.idx_end   = (idx_reg == used_reg);
    assign stat.used_full = (used_reg == DIW'(MAX_DEVICES));
    assign stat.cnt_zero  = (cnt_reg == '0);
    assign stat.j_end     = (j_reg == cnt_reg);
    assign stat.al_match  = al_match;
    assign stat.afound    = afound_reg;
    assign stat.sh_end    = (j_plus >= {1'b0, cnt_reg});
    assign stat.out_free  = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign res      = out_reg;

    `PDAT_ASSERT_SAME(a_used_bound, 1'b1, used_reg <= DIW'(MAX_DEVICES), "device count overflow")
    `PDAT_ASSERT_SAME(a_cnt_bound, dfound_reg, cnt_reg <= CW'(ALARMS_PER_DEVICE), "alarm count overflow")
    `PDAT_ASSERT_NEXT(a_emit_valid, cmd.op == OP_EMIT, out_valid_reg, "result not presented")
    `PDAT_ASSERT_SAME(a_emit_free, cmd.op == OP_EMIT, !out_valid_reg || m_tready, "result overwritten")

endmodule

// File: design/per_device_alarm_table.sv
// top level of the per-device alarm table
// A request is taken on the s_ channel and answered by exactly one result on
// the m_ channel. Requests are handled one at a time: a request walks the
// device entries (one read of the device store and one compare per entry),
// then the device's alarm list (a read and a compare per alarm), and a remove
// also compacts the list (a read and a write per moved alarm); a clear-all
// first sweeps the used device counts. These single-port memory loops set how
// long a request takes; the last step loads the output register, and a result
// held there by m_tready stalls the next request only at that last step.
// A new request is accepted while the previous result still waits there.
// table_enabled at byte address 0 (reset 1) gates all operations; when 0 each
// request gets status 3 and the table is untouched. Stores need no clearing
// pass after reset.
module per_device_alarm_table import pdat_pkg::*; #(
    parameter int MAX_DEVICES       = MAX_DEVICES_DEF,
    parameter int ALARMS_PER_DEVICE = ALARMS_PER_DEVICE_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // req_type[2:0], device_addr[18:3], endpoint_num[26:19], code_in[34:27],
    // cluster_in[50:35], report_time[82:51], now_time[114:83], zero pad
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // status[1:0], alarm_cnt[5:2], latest_found[6], latest_code[14:7],
    // latest_cluster[30:15], latest_stamp[62:31], device_endpoint[70:63],
    // received_total[102:71], cleared_total[134:103], zero pad
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [2:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    req_t     req_in;
    res_t     res;
    cmd_t     cmd;
    dp_stat_t stat;
    logic     enabled_reg;

    assign req_in = s_tdata;
    assign m_tdata = res;

    // configuration: one enable bit, written on the access phase
    assign pready = 1'b1;
    assign prdata = (paddr == REG_ENABLE) ? {31'd0, enabled_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enabled_reg <= 1'b1;
        end else if (psel && penable && pwrite && pready && paddr == REG_ENABLE) begin
            enabled_reg <= pwdata[0];
        end
    end

    // sequencer steps the datapath one operation per cycle, holding at its last step while the result is not taken
    pdat_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .enabled  (enabled_reg),
        .in_req   (req_in.req_type),
        .stat     (stat),
        .cmd      (cmd)
    );

    // device and alarm stores, counters and the result register
    pdat_dp #(
        .MAX_DEVICES       (MAX_DEVICES),
        .ALARMS_PER_DEVICE (ALARMS_PER_DEVICE)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req_in   (req_in),
        .cmd      (cmd),
        .stat     (stat),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .res      (res)
    );

endmodule

// File: bench/per_device_alarm_table_tb.sv
// self-checking testbench for the per-device alarm table
module per_device_alarm_table_tb;
    import pdat_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NDEV = MAX_DEVICES_DEF;
    localparam int NAL  = ALARMS_PER_DEVICE_DEF;
    localparam longint CYCLE_LIMIT = 1000000;

    logic                   aclk;
    logic                   aresetn;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [2:0]             paddr;
    logic [31:0]            pwdata;
    logic [31:0]            prdata;
    logic                   pready;

    per_device_alarm_table dut (.*);

    // clock, 10 ns period
    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // shadow copy of the table
    logic        sh_enabled;
    logic [15:0] sh_addr [NDEV];
    logic [7:0]  sh_ep [NDEV];
    int          sh_cnt [NDEV];
    int          sh_used;
    alarm_t      sh_alarm [NDEV][NAL];
    logic [31:0] sh_received;
    logic [31:0] sh_cleared;

    res_t  pending_results [$];
    int    error_count;
    int    sent_count;
    int    checked_count;
    int    out_wait;
    longint cycle_count;

    // the address pool keeps device hits frequent
    logic [15:0] addr_pool [24];

    function automatic int find_dev(logic [15:0] a);
        for (int i = 0; i < sh_used; i++)
            if (sh_addr[i] == a) return i;
        return -1;
    endfunction

    function automatic int find_alarm(int d, logic [7:0] c, logic [15:0] cl);
        for (int i = 0; i < sh_cnt[d]; i++)
            if (sh_alarm[d][i].code == c && sh_alarm[d][i].cluster == cl) return i;
        return -1;
    endfunction

    function automatic logic [1:0] insert_alarm(logic [15:0] a, logic [7:0] ep,
                                                logic [7:0] c, logic [15:0] cl,
                                                logic [31:0] t);
        int d;
        int s;
        d = find_dev(a);
        if (d < 0) begin
            if (sh_used >= NDEV) return STS_FULL;
            d = sh_used;
            sh_addr[d] = a;
            sh_ep[d] = ep;
            sh_cnt[d] = 0;
            sh_used++;
        end
        s = find_alarm(d, c, cl);
        if (s >= 0) begin
            sh_alarm[d][s].stamp = t;
            return STS_OK;
        end
        if (sh_cnt[d] >= NAL) begin
            // evict the oldest, lowest slot on a tie
            s = 0;
            for (int i = 1; i < NAL; i++)
                if (sh_alarm[d][i].stamp < sh_alarm[d][s].stamp) s = i;
        end else begin
            s = sh_cnt[d];
            sh_cnt[d]++;
        end
        sh_alarm[d][s] = '{code: c, cluster: cl, stamp: t};
        return STS_OK;
    endfunction

    // works out the result of one request and updates the shadow table
    function automatic res_t table_response(req_t r);
        res_t o;
        int d;
        int s;
        o = '0;
        if (!sh_enabled) begin
            o.status = STS_DISABLED;
            o.received_total = sh_received;
            o.cleared_total = sh_cleared;
            return o;
        end
        case (r.req_type)
            REQ_NOTIFY: begin
                o.status = insert_alarm(r.device_addr, r.endpoint_num, r.code_in,
                                        r.cluster_in, r.now_time);
                sh_received++;
            end
            REQ_REPORT: begin
                o.status = insert_alarm(r.device_addr, r.endpoint_num, r.code_in,
                                        r.cluster_in,
                                        r.report_time != 0 ? r.report_time : r.now_time);
            end
            REQ_REMOVE: begin
                d = find_dev(r.device_addr);
                s = d < 0 ? -1 : find_alarm(d, r.code_in, r.cluster_in);
                if (s < 0) begin
                    o.status = STS_NOT_FOUND;
                end else begin
                    for (int i = s; i + 1 < sh_cnt[d]; i++)
                        sh_alarm[d][i] = sh_alarm[d][i+1];
                    sh_cnt[d]--;
                    sh_cleared++;
                end
            end
            REQ_CLR_DEV: begin
                d = find_dev(r.device_addr);
                if (d >= 0) begin
                    sh_cleared += sh_cnt[d];
                    sh_cnt[d] = 0;
                end
            end
            REQ_CLR_ALL: begin
                for (int i = 0; i < sh_used; i++) begin
                    sh_cleared += sh_cnt[i];
                    sh_cnt[i] = 0;
                end
            end
            REQ_QUERY: begin
                d = find_dev(r.device_addr);
                if (d < 0 || sh_cnt[d] == 0) begin
                    o.status = STS_NOT_FOUND;
                end else begin
                    // newest wins, highest slot on a tie
                    s = 0;
                    for (int i = 1; i < sh_cnt[d]; i++)
                        if (sh_alarm[d][i].stamp >= sh_alarm[d][s].stamp) s = i;
                    o.latest_found = 1'b1;
                    o.latest_code = sh_alarm[d][s].code;
                    o.latest_cluster = sh_alarm[d][s].cluster;
                    o.latest_stamp = sh_alarm[d][s].stamp;
                end
            end
            default: ;
        endcase
        d = find_dev(r.device_addr);
        o.alarm_cnt = d < 0 ? 4'd0 : 4'(sh_cnt[d]);
        o.device_endpoint = d < 0 ? 8'd0 : sh_ep[d];
        o.received_total = sh_received;
        o.cleared_total = sh_cleared;
        return o;
    endfunction

    // drive one request; prediction is made at acceptance, then a random gap
    task automatic send_request(req_t r);
        int gap;
        s_tdata <= r;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(table_response(r));
        sent_count++;
        // with no gap valid stays up for the next request
        gap = $urandom_range(0, 3);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_fields(logic [2:0] op, logic [15:0] a, logic [7:0] ep,
                               logic [7:0] c, logic [15:0] cl, logic [31:0] rt,
                               logic [31:0] nt);
        req_t r;
        r = '0;
        r.req_type = op;
        r.device_addr = a;
        r.endpoint_num = ep;
        r.code_in = c;
        r.cluster_in = cl;
        r.report_time = rt;
        r.now_time = nt;
        send_request(r);
    endtask

    // wait for the table to drain so a register write lands while idle
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_enable(logic v);
        wait_drained();
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= REG_ENABLE;
        pwdata <= {31'd0, v};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sh_enabled = v;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // result checker; it also drives m_tready with random back-pressure on each result
    always @(posedge aclk) begin
        res_t got;
        res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected transfer %h", $time, got);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                checked_count++;
                if (got.status != want.status) begin
                    $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
                    error_count++;
                end
                if (got.alarm_cnt != want.alarm_cnt) begin
                    $display("%0t: alarm_cnt exp %0d got %0d", $time,
                             want.alarm_cnt, got.alarm_cnt);
                    error_count++;
                end
                if (got.latest_found != want.latest_found) begin
                    $display("%0t: latest_found exp %0d got %0d", $time,
                             want.latest_found, got.latest_found);
                    error_count++;
                end
                if (got.latest_code != want.latest_code) begin
                    $display("%0t: latest_code exp %h got %h", $time,
                             want.latest_code, got.latest_code);
                    error_count++;
                end
                if (got.latest_cluster != want.latest_cluster) begin
                    $display("%0t: latest_cluster exp %h got %h", $time,
                             want.latest_cluster, got.latest_cluster);
                    error_count++;
                end
                if (got.latest_stamp != want.latest_stamp) begin
                    $display("%0t: latest_stamp exp %h got %h", $time,
                             want.latest_stamp, got.latest_stamp);
                    error_count++;
                end
                if (got.device_endpoint != want.device_endpoint) begin
                    $display("%0t: device_endpoint exp %h got %h", $time,
                             want.device_endpoint, got.device_endpoint);
                    error_count++;
                end
                if (got.received_total != want.received_total) begin
                    $display("%0t: received_total exp %h got %h", $time,
                             want.received_total, got.received_total);
                    error_count++;
                end
                if (got.cleared_total != want.cleared_total) begin
                    $display("%0t: cleared_total exp %h got %h", $time,
                             want.cleared_total, got.cleared_total);
                    error_count++;
                end
            end
        end
        // draw a new wait after each transfer, count it down while a result waits
        if (m_tvalid && m_tready) begin
            out_wait = $urandom_range(0, 3);
        end else if (m_tvalid && out_wait > 0) begin
            out_wait--;
        end
        m_tready <= (out_wait == 0);
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // extremes, every operation and the named corner cases
    task automatic test_directed();
        send_fields(REQ_QUERY, 16'hFFFF, 8'h00, 8'h00, 16'h0000, 32'd0, 32'd0);
        send_fields(REQ_REMOVE, 16'hFFFF, 8'h00, 8'h11, 16'h2222, 32'd0, 32'd0);
        send_fields(REQ_CLR_DEV, 16'h1234, 8'h00, 8'h00, 16'h0000, 32'd0, 32'd0);
        send_fields(REQ_NOTIFY, 16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF,
                    32'hFFFF_FFFF);
        send_fields(REQ_REPORT, 16'hFFFF, 8'h00, 8'h00, 16'h0000, 32'd0, 32'h0000_0005);
        send_fields(REQ_REPORT, 16'h0000, 8'h5A, 8'h01, 16'h0001, 32'h10, 32'h99);
        send_fields(REQ_NOTIFY, 16'hFFFF, 8'h00, 8'hFF, 16'hFFFF, 32'd0, 32'h7);
        send_fields(REQ_QUERY, 16'hFFFF, 8'h00, 8'h00, 16'h0000, 32'd0, 32'd0);
        // fill one list past full with equal times to hit both tie rules
        for (int i = 0; i < NAL + 2; i++)
            send_fields(REQ_REPORT, 16'h0000, 8'h00, 8'(i + 2), 16'h0001, 32'h10, 32'd1);
        send_fields(REQ_QUERY, 16'h0000, 8'h00, 8'h00, 16'h0000, 32'd0, 32'd0);
        send_fields(REQ_REMOVE, 16'h0000, 8'h00, 8'h05, 16'h0001, 32'd0, 32'd0);
        send_fields(REQ_QUERY, 16'h0000, 8'h00, 8'h00, 16'h0000, 32'd0, 32'd0);
        send_fields(REQ_SPARE_A, 16'h0000, 8'h00, 8'h00, 16'h0000, 32'd0, 32'd0);
        send_fields(REQ_SPARE_B, 16'hFFFF, 8'h00, 8'h00, 16'h0000, 32'd0, 32'd0);
        send_fields(REQ_CLR_DEV, 16'hFFFF, 8'h00, 8'h00, 16'h0000, 32'd0, 32'd0);
        send_fields(REQ_QUERY, 16'hFFFF, 8'h00, 8'h00, 16'h0000, 32'd0, 32'd0);
        send_fields(REQ_CLR_ALL, 16'h0000, 8'h00, 8'h00, 16'h0000, 32'd0, 32'd0);
    endtask

    // fill the device table and try one more device
    task automatic test_table_full();
        for (int i = 0; i < NDEV + 2; i++)
            send_fields(REQ_NOTIFY, addr_pool[i], 8'($urandom), 8'h01, 16'h0006,
                        32'd0, 32'($urandom));
        send_fields(REQ_REPORT, 16'hBEEF, 8'h01, 8'h02, 16'h0003, 32'd0, 32'h1);
    endtask

    task automatic random_request();
        req_t r;
        int k;
        r = IN_TDATA_W'({$urandom, $urandom, $urandom, $urandom});
        r.pad = '0;
        k = $urandom_range(0, 99);
        if (k < 30) r.req_type = REQ_NOTIFY;
        else if (k < 55) r.req_type = REQ_REPORT;
        else if (k < 70) r.req_type = REQ_REMOVE;
        else if (k < 76) r.req_type = REQ_CLR_DEV;
        else if (k < 78) r.req_type = REQ_CLR_ALL;
        else if (k < 97) r.req_type = REQ_QUERY;
        else if ($urandom_range(0, 1) == 0) r.req_type = REQ_SPARE_A;
        else r.req_type = REQ_SPARE_B;
        // mostly known devices and a small alarm space so duplicates happen
        if ($urandom_range(0, 9) != 0) begin
            r.device_addr = addr_pool[$urandom_range(0, 23)];
            r.code_in = 8'($urandom_range(0, 11));
            r.cluster_in = 16'($urandom_range(0, 1));
            if ($urandom_range(0, 3) != 0) r.now_time = 32'($urandom_range(0, 40));
            if ($urandom_range(0, 2) == 0) r.report_time = 0;
            else if ($urandom_range(0, 1) == 0) r.report_time = 32'($urandom_range(0, 40));
        end
        send_request(r);
    endtask

    task automatic test_random(int n);
        for (int i = 0; i < n; i++) random_request();
    endtask

    // disabled table answers every request and changes nothing
    task automatic test_disabled();
        write_enable(1'b0);
        for (int i = 0; i < 40; i++) random_request();
        write_enable(1'b1);
    endtask

    initial begin
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        m_tready <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        error_count = 0;
        sent_count = 0;
        checked_count = 0;
        out_wait = 0;
        cycle_count = 0;
        sh_enabled = 1'b1;
        sh_used = 0;
        sh_received = 0;
        sh_cleared = 0;
        for (int i = 0; i < NDEV; i++) sh_cnt[i] = 0;
        addr_pool[0] = 16'h0000;
        addr_pool[1] = 16'hFFFF;
        for (int i = 2; i < 24; i++) addr_pool[i] = 16'($urandom);
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        write_enable(1'b1);
        test_directed();
        test_disabled();
        test_random(600);
        // hold off until the table has answered everything
        wait_drained();
        test_table_full();
        test_random(700);
        test_disabled();
        test_random(60);

        wait_drained();
        repeat (100) @(posedge aclk);
        $display("sent %0d requests, checked %0d results, all request kinds", sent_count,
                 checked_count);
        $display("covered: full lists, full device table, disabled phases, idle stalls");
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

// File: per_device_alarm_table.f
+incdir+design
design/pdat_pkg.sv
design/pdat_ctrl.sv
design/pdat_dp.sv
design/per_device_alarm_table.sv
bench/per_device_alarm_table_tb.sv
